/* hdl/llc_pkg.sv */
// llc_pkg: shared types, constants and helpers for the lane obstacle counter
// used by the channel interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package llc_pkg;

  localparam int MAX_GAP_INDEX_DEF = 19;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int AHEAD_NEAR = 250;
  localparam int AHEAD_FAR  = 1000;
  localparam int SIDE_INSET = 150;
  localparam int Q14_HALF   = 8192;

  localparam logic signed [15:0] Q14_POS = 16'sd16384;
  localparam logic signed [15:0] Q14_NEG = -16'sd16384;
  localparam logic signed [15:0] COS_POS = 16'sd11586;
  localparam logic signed [15:0] COS_NEG = -16'sd11586;

  localparam logic signed [31:0] POS_MIN = -32'sd524288;
  localparam logic signed [31:0] POS_MAX = 32'sd524287;

  localparam logic [15:0] HITS_MAX     = 16'hFFFF;
  localparam logic [15:0] THRESH_RESET = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_START_X = 3'd0,
    CFG_FIELD_START_Y = 3'd1,
    CFG_ROW_LENGTH    = 3'd2,
    CFG_ROW_WIDTH     = 3'd3,
    CFG_GAP_WIDTH     = 3'd4,
    CFG_HIT_THRESHOLD = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    BOX_NONE = 2'd0,
    BOX_UP   = 2'd1,
    BOX_DOWN = 2'd2
  } box_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MODE,
    S_MUL,
    S_ACC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               req_type;
    logic signed [19:0] pose_x;
    logic signed [19:0] pose_y;
    logic signed [15:0] heading_cos;
    logic signed [15:0] heading_sin;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic               blocked;
    logic [15:0]        hit_count;
    logic signed [19:0] box_centre_x;
    logic signed [19:0] box_centre_y;
    logic               box_active;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic search;
    logic set_box;
    logic mul;
    logic acc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_point;
    logic last;
    logic gap_found;
    logic gap_end;
    logic out_free;
  } status_t;

  // clamp to the 20 bit signed position range
  function automatic logic signed [19:0] sat20(input logic signed [31:0] v);
    logic signed [19:0] r;
    if (v < POS_MIN) begin
      r = POS_MIN[19:0];
    end else if (v > POS_MAX) begin
      r = POS_MAX[19:0];
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/llc_if.sv */
// llc_if: valid/ready channel interfaces for pose/point items and result items
// depends on llc_pkg for the payload structs
`timescale 1ns / 1ps
`default_nettype none

interface llc_in_if;
  logic               valid;
  logic               ready;
  llc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface llc_out_if;
  logic               valid;
  logic               ready;
  llc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/llc_ctrl.sv */
// llc_ctrl: sequencer for scan start (gap search, box set) and point items
// depends on llc_pkg for state, command and status types
`timescale 1ns / 1ps
`default_nettype none

module llc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire llc_pkg::status_t status,
  output llc_pkg::cmd_t        cmd
);

  llc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= llc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      llc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = status.in_point ? llc_pkg::S_MUL : llc_pkg::S_SEARCH;
        end
      end
      llc_pkg::S_SEARCH: begin
        if (status.gap_found) begin
          state_nxt = llc_pkg::S_MODE;
        end else if (status.gap_end) begin
          state_nxt = llc_pkg::S_IDLE;
        end
      end
      llc_pkg::S_MODE: state_nxt = llc_pkg::S_IDLE;
      llc_pkg::S_MUL:  state_nxt = llc_pkg::S_ACC;
      llc_pkg::S_ACC: begin
        state_nxt = status.last ? llc_pkg::S_EMIT : llc_pkg::S_IDLE;
      end
      llc_pkg::S_EMIT: begin
        if (status.out_free) begin
          state_nxt = llc_pkg::S_IDLE;
        end
      end
      default: state_nxt = llc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      llc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      llc_pkg::S_SEARCH: cmd.search  = 1'b1;
      llc_pkg::S_MODE:   cmd.set_box = 1'b1;
      llc_pkg::S_MUL:    cmd.mul     = 1'b1;
      llc_pkg::S_ACC:    cmd.acc     = 1'b1;
      llc_pkg::S_EMIT:   cmd.emit    = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/llc_datapath.sv */
// llc_datapath: config registers, gap search adder, box bounds, point rotation
// and hit counter, result register; depends on llc_pkg
`timescale 1ns / 1ps
`default_nettype none

module llc_datapath #(
  parameter int MAX_GAP_INDEX = llc_pkg::MAX_GAP_INDEX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [llc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [llc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire llc_pkg::in_item_t                 in_item,
  input  wire llc_pkg::cmd_t                     cmd,
  output llc_pkg::status_t                       status,
  output llc_pkg::out_item_t                     out_item,
  output logic                                   out_valid,
  input  wire logic                              out_ready
);

  localparam int GW = $clog2(MAX_GAP_INDEX + 1);
  localparam int LW = GW + 21;
  localparam int YW = 23;

  // configuration
  logic signed [19:0] fsx_r, fsy_r;
  logic [18:0]        row_len_r;
  logic [15:0]        row_w_r, gap_w_r, thr_r;

  // scan state
  logic signed [19:0]  veh_x_r, veh_y_r;
  logic signed [15:0]  cos_r, sin_r;
  llc_pkg::box_mode_t  box_mode_r;
  logic signed [19:0]  box_xlo_r, box_xhi_r, box_ylo_r, box_yhi_r;
  logic [15:0]         hits_r;

  // gap search
  logic signed [LW-1:0] left_r;
  logic [GW-1:0]        gap_idx_r;

  // point pipeline
  logic signed [15:0] px_r, py_r;
  logic               last_r;
  logic signed [31:0] p_yc_r, p_xs_r, p_ys_r, p_xc_r;

  llc_pkg::out_item_t out_r;
  logic               out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsx_r     <= '0;
      fsy_r     <= '0;
      row_len_r <= '0;
      row_w_r   <= '0;
      gap_w_r   <= '0;
      thr_r     <= llc_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      case (llc_pkg::cfg_index_t'(cfg_index))
        llc_pkg::CFG_FIELD_START_X: fsx_r     <= cfg_wdata;
        llc_pkg::CFG_FIELD_START_Y: fsy_r     <= cfg_wdata;
        llc_pkg::CFG_ROW_LENGTH:    row_len_r <= cfg_wdata[18:0];
        llc_pkg::CFG_ROW_WIDTH:     row_w_r   <= cfg_wdata[15:0];
        llc_pkg::CFG_GAP_WIDTH:     gap_w_r   <= cfg_wdata[15:0];
        llc_pkg::CFG_HIT_THRESHOLD: thr_r     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // gap sides: one gap tested per search step
  logic signed [LW-1:0] vx_ext, row_ext, gap_ext, right_w;
  logic                 gap_found, gap_end;

  assign vx_ext    = LW'(veh_x_r);
  assign row_ext   = LW'(row_w_r);
  assign gap_ext   = LW'(gap_w_r);
  assign right_w   = left_r + gap_ext;
  assign gap_found = (vx_ext > left_r) && (vx_ext < right_w);
  assign gap_end   = gap_idx_r == GW'(MAX_GAP_INDEX);

  // box bounds from the found gap and the heading
  logic signed [YW-1:0] vy_ext, sy_ext, len_ext, up_hi, dn_lo, dn_hi;
  logic                 head_ok, up_ok, dn_ok;
  logic signed [31:0]   xlo_w, xhi_w;

  assign vy_ext  = YW'(veh_y_r);
  assign sy_ext  = YW'(fsy_r);
  assign len_ext = YW'(row_len_r);
  assign up_hi   = sy_ext + len_ext - YW'(llc_pkg::AHEAD_FAR);
  assign dn_lo   = sy_ext + YW'(llc_pkg::AHEAD_FAR);
  assign dn_hi   = sy_ext + len_ext;
  assign head_ok = (cos_r >= llc_pkg::Q14_NEG) && (cos_r <= llc_pkg::Q14_POS) &&
                   (sin_r >= llc_pkg::Q14_NEG) && (sin_r <= llc_pkg::Q14_POS);
  assign up_ok   = head_ok && (cos_r >= llc_pkg::COS_POS) &&
                   (vy_ext > sy_ext) && (vy_ext < up_hi);
  assign dn_ok   = head_ok && (cos_r <= llc_pkg::COS_NEG) &&
                   (vy_ext > dn_lo) && (vy_ext < dn_hi);
  assign xlo_w   = 32'(left_r) + 32'(llc_pkg::SIDE_INSET);
  assign xhi_w   = 32'(right_w) - 32'(llc_pkg::SIDE_INSET);

  // rotated offsets rounded to whole millimetres, halves up
  logic signed [32:0] dx_sum, dy_sum, dx_rnd, dy_rnd;
  logic signed [18:0] dx, dy;
  logic signed [20:0] tx, ty;
  logic               hit;

  assign dx_sum = 33'(p_yc_r) - 33'(p_xs_r);
  assign dy_sum = 33'(p_ys_r) + 33'(p_xc_r);
  assign dx_rnd = dx_sum + 33'(llc_pkg::Q14_HALF);
  assign dy_rnd = dy_sum + 33'(llc_pkg::Q14_HALF);
  assign dx     = dx_rnd[32:14];
  assign dy     = dy_rnd[32:14];
  assign tx     = 21'(veh_x_r) + 21'(dx);
  assign ty     = 21'(veh_y_r) + 21'(dy);
  assign hit    = (box_mode_r != llc_pkg::BOX_NONE) &&
                  (tx > 21'(box_xlo_r)) && (tx < 21'(box_xhi_r)) &&
                  (ty > 21'(box_ylo_r)) && (ty < 21'(box_yhi_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      veh_x_r    <= '0;
      veh_y_r    <= '0;
      cos_r      <= '0;
      sin_r      <= '0;
      box_mode_r <= llc_pkg::BOX_NONE;
      box_xlo_r  <= '0;
      box_xhi_r  <= '0;
      box_ylo_r  <= '0;
      box_yhi_r  <= '0;
      hits_r     <= '0;
      gap_idx_r  <= '0;
    end else begin
      if (cmd.load && !in_item.req_type) begin
        veh_x_r    <= in_item.pose_x;
        veh_y_r    <= in_item.pose_y;
        cos_r      <= in_item.heading_cos;
        sin_r      <= in_item.heading_sin;
        box_mode_r <= llc_pkg::BOX_NONE;
        box_xlo_r  <= '0;
        box_xhi_r  <= '0;
        box_ylo_r  <= '0;
        box_yhi_r  <= '0;
        hits_r     <= '0;
        gap_idx_r  <= GW'(1);
      end
      if (cmd.search && !gap_found && !gap_end) begin
        gap_idx_r <= gap_idx_r + GW'(1);
      end
      if (cmd.set_box && (up_ok || dn_ok)) begin
        box_mode_r <= up_ok ? llc_pkg::BOX_UP : llc_pkg::BOX_DOWN;
        box_xlo_r  <= llc_pkg::sat20(xlo_w);
        box_xhi_r  <= llc_pkg::sat20(xhi_w);
        if (up_ok) begin
          box_ylo_r <= llc_pkg::sat20(32'(vy_ext) + 32'(llc_pkg::AHEAD_NEAR));
          box_yhi_r <= llc_pkg::sat20(32'(vy_ext) + 32'(llc_pkg::AHEAD_FAR));
        end else begin
          box_ylo_r <= llc_pkg::sat20(32'(vy_ext) - 32'(llc_pkg::AHEAD_FAR));
          box_yhi_r <= llc_pkg::sat20(32'(vy_ext) - 32'(llc_pkg::AHEAD_NEAR));
        end
      end
      if (cmd.acc && hit && (hits_r != llc_pkg::HITS_MAX)) begin
        hits_r <= hits_r + 16'd1;
      end
    end
  end

  // search walker and point operands carry no reset
  always_ff @(posedge clk) begin
    if (cmd.load && !in_item.req_type) begin
      left_r <= LW'(fsx_r) + row_ext;
    end else if (cmd.search && !gap_found && !gap_end) begin
      left_r <= left_r + row_ext + gap_ext;
    end
    if (cmd.load) begin
      px_r   <= in_item.point_x;
      py_r   <= in_item.point_y;
      last_r <= in_item.last_point;
    end
    if (cmd.mul) begin
      p_yc_r <= py_r * cos_r;
      p_xs_r <= px_r * sin_r;
      p_ys_r <= py_r * sin_r;
      p_xc_r <= px_r * cos_r;
    end
  end

  logic signed [20:0] cx_sum, cy_sum;
  logic               active;

  assign cx_sum = 21'(box_xlo_r) + 21'(box_xhi_r);
  assign cy_sum = 21'(box_ylo_r) + 21'(box_yhi_r);
  assign active = box_mode_r != llc_pkg::BOX_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.blocked      <= hits_r > thr_r;
      out_r.hit_count    <= hits_r;
      out_r.box_centre_x <= active ? cx_sum[20:1] : '0;
      out_r.box_centre_y <= active ? cy_sum[20:1] : '0;
      out_r.box_active   <= active;
    end
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

  assign status.in_point  = in_item.req_type;
  assign status.last      = last_r;
  assign status.gap_found = gap_found;
  assign status.gap_end   = gap_end;
  assign status.out_free  = !out_valid_r || out_ready;

  a_hits_src: assert property (@(posedge clk) disable iff (!rst_n)
    (hits_r != $past(hits_r)) |-> ($past(cmd.acc) || $past(cmd.load)))
    else $error("hit count changed outside a point or scan start");

  a_box_src: assert property (@(posedge clk) disable iff (!rst_n)
    (box_mode_r != $past(box_mode_r)) |-> ($past(cmd.set_box) || $past(cmd.load)))
    else $error("box mode changed outside box setup");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwrote an item not yet taken");

endmodule

`default_nettype wire

/* hdl/lidar_lane_obstacle_counter.sv */
// lidar_lane_obstacle_counter: top level, joins the controller and the datapath
// depends on llc_pkg, llc_if, llc_ctrl and llc_datapath
//
// A scan start item (req_type 0) latches the pose and searches the gaps between
// rows one gap per cycle, then, when the vehicle sits in a gap and heading and
// position allow it, sets the detection box; it returns nothing. A lidar point
// item (req_type 1) is accepted, then the four 16x16 rotation products are
// registered, then round, translate, box compare and count follow. A point with
// last_point set then loads the result register once the previous result has
// been taken; the register holds the result until taken while the next item is
// accepted. Configuration is written through cfg_we, cfg_index and cfg_wdata
// while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module lidar_lane_obstacle_counter #(
  parameter int MAX_GAP_INDEX = llc_pkg::MAX_GAP_INDEX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  llc_in_if.sink                              in_ch,
  llc_out_if.source                           out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [llc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [llc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  llc_pkg::cmd_t      cmd;
  llc_pkg::status_t   status;
  llc_pkg::out_item_t out_item;
  logic               in_ready;
  logic               out_valid;

  llc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  llc_datapath #(
    .MAX_GAP_INDEX (MAX_GAP_INDEX)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ch.ready)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

endmodule

`default_nettype wire

/* test/lidar_lane_obstacle_counter_tb.sv */
`timescale 1ns / 1ps
// lidar_lane_obstacle_counter_tb: self-checking bench for the lane obstacle counter
// feeds scan start and lidar point items with random gaps, predicts every report
// depends on llc_pkg, llc_if and the lidar_lane_obstacle_counter top level

module lidar_lane_obstacle_counter_tb;

  localparam int NUM_GAPS      = 19;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_SHOWN     = 10;
  localparam int N_HEADINGS    = 12;
  localparam int HIT_MAX       = 65535;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [llc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [llc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  llc_in_if  in_ch ();
  llc_out_if out_ch ();

  lidar_lane_obstacle_counter #(
    .MAX_GAP_INDEX(NUM_GAPS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  llc_pkg::in_item_t  scan_feed[$];
  llc_pkg::out_item_t pending_reports[$];

  // register copy and state of the obstacle predictor
  longint    cf_start_x = 0, cf_start_y = 0, cf_row_len = 0;
  longint    cf_row_w = 0, cf_gap_w = 0, cf_thresh = llc_pkg::THRESH_RESET;
  longint    veh_x = 0, veh_y = 0, veh_cos = 0, veh_sin = 0;
  llc_pkg::box_mode_t bx_mode = llc_pkg::BOX_NONE;
  longint    bx_xlo = 0, bx_xhi = 0, bx_ylo = 0, bx_yhi = 0;
  int        hit_total = 0;

  // field geometry used to aim stimulus
  longint pl_start_x, pl_start_y, pl_row_len, pl_row_w, pl_gap_w;

  int n_bad = 0;
  int send_gap, rcv_wait, rcv_draw, hold_left, idle_cycles;
  bit send_idle_on = 1'b1, rcv_idle_on = 1'b1, hold_arm = 1'b0, hold_done = 1'b0;

  // headings: first eight give a mode, the last four sit on or past the limits
  int hd_cos [N_HEADINGS] = '{16384, -16384, 14189, 14189, -14189, -14189,
                              15826, -15826, 11586, -11586, 11585, 0};
  int hd_sin [N_HEADINGS] = '{0, 0, 8192, -8192, 8192, -8192,
                              4240, -4240, 11585, 11585, 11585, 16384};

  function automatic void add_item(llc_pkg::in_item_t it);
    scan_feed.insert(scan_feed.size(), it);
  endfunction

  function automatic longint clip_pos(longint v);
    if (v < -524288) return -524288;
    if (v > 524287) return 524287;
    return v;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    longint c;
    c = (v < -32768) ? -32768 : ((v > 32767) ? 32767 : v);
    return c[15:0];
  endfunction

  function automatic void place_box();
    longint left, right, ylo, yhi;
    bit found;
    left = 0;
    right = 0;
    ylo = 0;
    yhi = 0;
    found = 1'b0;
    bx_mode = llc_pkg::BOX_NONE;
    bx_xlo = 0;
    bx_xhi = 0;
    bx_ylo = 0;
    bx_yhi = 0;
    for (int g = 1; g <= NUM_GAPS && !found; g++) begin
      left = cf_start_x + g * cf_row_w + (g - 1) * cf_gap_w;
      right = left + cf_gap_w;
      if (veh_x > left && veh_x < right) found = 1'b1;
    end
    if (!found) return;
    if (veh_cos < llc_pkg::Q14_NEG || veh_cos > llc_pkg::Q14_POS ||
        veh_sin < llc_pkg::Q14_NEG || veh_sin > llc_pkg::Q14_POS)
      return;
    if (veh_cos >= llc_pkg::COS_POS) begin
      if (!(veh_y > cf_start_y && veh_y < cf_start_y + cf_row_len - llc_pkg::AHEAD_FAR))
        return;
      ylo = veh_y + llc_pkg::AHEAD_NEAR;
      yhi = veh_y + llc_pkg::AHEAD_FAR;
      bx_mode = llc_pkg::BOX_UP;
    end else if (veh_cos <= llc_pkg::COS_NEG) begin
      if (!(veh_y > cf_start_y + llc_pkg::AHEAD_FAR && veh_y < cf_start_y + cf_row_len))
        return;
      ylo = veh_y - llc_pkg::AHEAD_FAR;
      yhi = veh_y - llc_pkg::AHEAD_NEAR;
      bx_mode = llc_pkg::BOX_DOWN;
    end else begin
      return;
    end
    bx_xlo = clip_pos(left + llc_pkg::SIDE_INSET);
    bx_xhi = clip_pos(right - llc_pkg::SIDE_INSET);
    bx_ylo = clip_pos(ylo);
    bx_yhi = clip_pos(yhi);
  endfunction

  function automatic void track_item(llc_pkg::in_item_t it);
    longint px, py, tx, ty, cx, cy;
    llc_pkg::out_item_t r;
    if (it.req_type == 1'b0) begin
      veh_x = $signed(it.pose_x);
      veh_y = $signed(it.pose_y);
      veh_cos = $signed(it.heading_cos);
      veh_sin = $signed(it.heading_sin);
      hit_total = 0;
      place_box();
      return;
    end
    px = $signed(it.point_x);
    py = $signed(it.point_y);
    if (bx_mode != llc_pkg::BOX_NONE) begin
      tx = veh_x + ((py * veh_cos - px * veh_sin + llc_pkg::Q14_HALF) >>> 14);
      ty = veh_y + ((py * veh_sin + px * veh_cos + llc_pkg::Q14_HALF) >>> 14);
      if (tx > bx_xlo && tx < bx_xhi && ty > bx_ylo && ty < bx_yhi && hit_total < HIT_MAX)
        hit_total++;
    end
    if (!it.last_point) return;
    cx = (bx_xlo + bx_xhi) >>> 1;
    cy = (bx_ylo + bx_yhi) >>> 1;
    r.blocked = (hit_total > cf_thresh);
    r.hit_count = hit_total[15:0];
    r.box_active = (bx_mode != llc_pkg::BOX_NONE);
    r.box_centre_x = r.box_active ? cx[19:0] : '0;
    r.box_centre_y = r.box_active ? cy[19:0] : '0;
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  function automatic llc_pkg::in_item_t raw_item();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(llc_pkg::in_item_t)-1:0];
  endfunction

  function automatic llc_pkg::in_item_t pose_item(longint x, longint y, longint c, longint s);
    llc_pkg::in_item_t it;
    it = raw_item();
    it.req_type = 1'b0;
    it.pose_x = x[19:0];
    it.pose_y = y[19:0];
    it.heading_cos = c[15:0];
    it.heading_sin = s[15:0];
    return it;
  endfunction

  function automatic llc_pkg::in_item_t point_item(longint px, longint py, bit is_last);
    llc_pkg::in_item_t it;
    it = raw_item();
    it.req_type = 1'b1;
    it.point_x = clip16(px);
    it.point_y = clip16(py);
    it.last_point = is_last;
    return it;
  endfunction

  // point in the vehicle frame that lands at field offset (ox, oy) from the vehicle
  function automatic llc_pkg::in_item_t aim(longint ox, longint oy, longint c, longint s,
                                            bit is_last);
    return point_item((c * oy - s * ox + llc_pkg::Q14_HALF) >>> 14,
                      (c * ox + s * oy + llc_pkg::Q14_HALF) >>> 14, is_last);
  endfunction

  task automatic settle();
    do @(negedge clk);
    while (scan_feed.size() != 0 || in_ch.valid || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(llc_pkg::cfg_index_t idx, longint v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[19:0];
    case (idx)
      llc_pkg::CFG_FIELD_START_X: cf_start_x = $signed(v[19:0]);
      llc_pkg::CFG_FIELD_START_Y: cf_start_y = $signed(v[19:0]);
      llc_pkg::CFG_ROW_LENGTH:    cf_row_len = v[18:0];
      llc_pkg::CFG_ROW_WIDTH:     cf_row_w = v[15:0];
      llc_pkg::CFG_GAP_WIDTH:     cf_gap_w = v[15:0];
      llc_pkg::CFG_HIT_THRESHOLD: cf_thresh = v[15:0];
      default: ;
    endcase
  endtask

  task automatic set_field(longint fsx, longint fsy, longint len, longint rw, longint gw,
                           longint th);
    settle();
    pl_start_x = fsx;
    pl_start_y = fsy;
    pl_row_len = len;
    pl_row_w = rw;
    pl_gap_w = gw;
    write_reg(llc_pkg::CFG_FIELD_START_X, fsx);
    write_reg(llc_pkg::CFG_FIELD_START_Y, fsy);
    write_reg(llc_pkg::CFG_ROW_LENGTH, len);
    write_reg(llc_pkg::CFG_ROW_WIDTH, rw);
    write_reg(llc_pkg::CFG_GAP_WIDTH, gw);
    write_reg(llc_pkg::CFG_HIT_THRESHOLD, th);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_field();
    set_field(longint'($urandom_range(0, 10000)) - 5000,
              longint'($urandom_range(0, 10000)) - 5000,
              $urandom_range(3000, 60000), $urandom_range(200, 1500),
              $urandom_range(400, 3000), $urandom_range(0, 20));
  endtask

  // one scan: pose inside a gap most of the time, then points aimed around the box
  function automatic int feed_scan(int n_pts);
    longint left, vx, vy, c, s, ylo, yhi, ox, oy, near_y;
    int k, g, wx;
    bit up;
    k = $urandom_range(0, N_HEADINGS - 1);
    c = hd_cos[k];
    s = hd_sin[k];
    g = $urandom_range(1, NUM_GAPS);
    left = pl_start_x + g * pl_row_w + (g - 1) * pl_gap_w;
    vx = (pl_gap_w >= 2) ? left + 1 + $urandom_range(0, int'(pl_gap_w) - 2) : left + 1;
    up = (c > 0);
    ylo = up ? pl_start_y + 1 : pl_start_y + llc_pkg::AHEAD_FAR + 1;
    yhi = up ? pl_start_y + pl_row_len - llc_pkg::AHEAD_FAR - 1 : pl_start_y + pl_row_len - 1;
    vy = (yhi >= ylo) ? ylo + $urandom_range(0, int'(yhi - ylo)) : ylo;
    if ($urandom_range(0, 7) == 0) vy = $urandom_range(0, 1) ? ylo - 1 : yhi + 1;
    vx = clip_pos(vx);
    vy = clip_pos(vy);
    if ($urandom_range(0, 7) == 0) add_item(pose_item($urandom, $urandom,
                                                      $urandom, $urandom));
    else add_item(pose_item(vx, vy, c, s));
    near_y = up ? llc_pkg::AHEAD_NEAR : -llc_pkg::AHEAD_FAR;
    wx = int'(pl_gap_w) - 100;
    if (wx < 0) wx = 0;
    for (int i = 0; i < n_pts; i++) begin
      ox = left + 50 - vx + $urandom_range(0, wx);
      oy = near_y - 100 + $urandom_range(0, 950);
      if ($urandom_range(0, 9) == 0)
        add_item(point_item($signed(16'($urandom)), $signed(16'($urandom)),
                            (i == n_pts - 1) || ($urandom_range(0, 15) == 0)));
      else
        add_item(aim(ox, oy, c, s, (i == n_pts - 1) || ($urandom_range(0, 15) == 0)));
    end
    return n_pts + 1;
  endfunction

  task automatic feed_random(int n_items);
    int count;
    count = 0;
    while (count < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat (3) add_item(raw_item());
        count += 3;
      end else begin
        count += feed_scan($urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sender: one item at a time, a drawn gap after each accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) track_item(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          in_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (scan_feed.size() > 0) begin
          in_ch.data <= scan_feed.pop_front();
          in_ch.valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_idle_on = !send_idle_on;
          send_gap <= send_idle_on ? $urandom_range(0, 3) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_report(llc_pkg::out_item_t got);
    llc_pkg::out_item_t want;
    if (pending_reports.size() == 0) begin
      n_bad++;
      if (n_bad <= MAX_SHOWN)
        $display("unexpected report: blocked %0d hits %0d centre %0d,%0d active %0d",
                 got.blocked, got.hit_count, $signed(got.box_centre_x),
                 $signed(got.box_centre_y), got.box_active);
      return;
    end
    want = pending_reports.pop_front();
    if (got.blocked !== want.blocked || got.hit_count !== want.hit_count ||
        got.box_centre_x !== want.box_centre_x || got.box_centre_y !== want.box_centre_y ||
        got.box_active !== want.box_active) begin
      n_bad++;
      if (n_bad <= MAX_SHOWN)
        $display("mismatch exp/got: blk %0d/%0d hits %0d/%0d cx %0d/%0d cy %0d/%0d act %0d/%0d",
                 want.blocked, got.blocked, want.hit_count, got.hit_count,
                 $signed(want.box_centre_x), $signed(got.box_centre_x),
                 $signed(want.box_centre_y), $signed(got.box_centre_y),
                 want.box_active, got.box_active);
    end
  endtask

  // receiver: drawn stall after each report, one long hold-off when armed
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rcv_wait <= 0;
      hold_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_report(out_ch.data);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_left <= LONG_HOLD;
        hold_done <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        if ($urandom_range(0, 39) == 0) rcv_idle_on = !rcv_idle_on;
        rcv_draw = rcv_idle_on ? $urandom_range(0, 3) : 0;
        rcv_wait <= (rcv_draw > 0) ? rcv_draw - 1 : 0;
        out_ch.ready <= (rcv_draw == 0);
      end else if (rcv_wait > 0) begin
        out_ch.ready <= 1'b0;
        rcv_wait <= rcv_wait - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("lidar_lane_obstacle_counter_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = llc_pkg::CFG_FIELD_START_X;
    cfg_wdata = '0;
    pl_start_x = 0;
    pl_start_y = 0;
    pl_row_len = 0;
    pl_row_w = 0;
    pl_gap_w = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: points before any scan, then a scan that finds no gap
    add_item(point_item(32767, -32768, 1'b1));
    add_item(pose_item($urandom, $urandom, 16384, 0));
    add_item(point_item(0, 0, 1'b1));

    // gap 3 spans 7000..8600, box x 7150..8450, rows from y -3000 to 37000
    set_field(2000, -3000, 40000, 600, 1600, 0);
    add_item(pose_item(7800, 0, 16384, 0));
    add_item(aim(0, 600, 16384, 0, 1'b0));
    add_item(aim(1000, 600, 16384, 0, 1'b0));
    add_item(point_item(32767, -32768, 1'b1));
    add_item(pose_item(7800, 0, 11586, 11585));
    add_item(aim(0, 600, 11586, 11585, 1'b1));
    add_item(pose_item(7800, 0, 11585, 11586));
    add_item(aim(0, 600, 11585, 11586, 1'b1));
    add_item(pose_item(7800, 10000, -11586, -11585));
    add_item(aim(0, -600, -11586, -11585, 1'b0));
    add_item(aim(0, -600, -11586, -11585, 1'b1));
    add_item(pose_item(7800, 10000, -11585, 0));
    add_item(aim(0, -600, -11585, 0, 1'b1));
    // heading outside the unit range
    add_item(pose_item(7800, 0, 16385, 0));
    add_item(aim(0, 600, 16384, 0, 1'b1));
    add_item(pose_item(7800, 0, 16384, -16385));
    add_item(aim(0, 600, 16384, 0, 1'b1));
    // vehicle on the gap edge, then too close to the row end
    add_item(pose_item(7000, 0, 16384, 0));
    add_item(aim(0, 600, 16384, 0, 1'b1));
    add_item(pose_item(7800, 36000, 16384, 0));
    add_item(aim(0, 600, 16384, 0, 1'b1));
    // counting goes on past the last point
    add_item(pose_item(7800, 0, 16384, 0));
    add_item(aim(0, 600, 16384, 0, 1'b1));
    add_item(aim(0, 600, 16384, 0, 1'b0));
    add_item(point_item(-32768, 32767, 1'b1));

    // box bounds clipped at the top of the position range
    set_field(523000, 500000, 524287, 0, 65535, 65535);
    add_item(pose_item(524287, 524000, 16384, 0));
    add_item(aim(-500, 270, 16384, 0, 1'b1));
    add_item(pose_item(524287, 510000, -16384, 0));
    add_item(aim(-500, -600, -16384, 0, 1'b0));
    add_item(point_item(0, 0, 1'b1));

    set_field(524287, 524287, 524287, 65535, 65535, 65535);
    void'(feed_scan(2));
    void'(feed_scan(2));

    random_field();
    feed_random(100);

    random_field();
    hold_arm = 1'b1;
    feed_random(120);

    set_field(-524288, -524288, 524287, 65535, 65535, 65535);
    feed_random(60);

    random_field();
    feed_random(130);

    settle();
    if (n_bad == 0) begin
      $display("lidar_lane_obstacle_counter_tb OK");
    end else begin
      $display("lidar_lane_obstacle_counter_tb NOT OK");
    end
    $finish;
  end

endmodule
